/* rtl/pal_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the positional array list unit.
// No dependencies.
package pal_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOKEY  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

endpackage

/* rtl/positional_array_list.sv */
`timescale 1ns / 1ps
// Positional array list: ordered key/payload list held in register cells.
// Input channel i_valid/o_stall takes one action word (clear, insert, append,
// delete, read, update, find); output channel o_valid/i_stall returns one
// result word per action: status, found position, key, payload and count.
// Sequence: a word accepted in S_IDLE is registered, then goes to S_WRITE, which
// commits the result to the output register once that register is free; all
// actions but find go there directly. Find first walks the cells one per cycle
// in S_SCAN from position 0 and stops at the first match or the last entry. The
// cell scan is what sets find latency.
// The block takes no new word until the last action has committed; o_stall is
// high while an action is in flight.
// Stall: the result sits in the output register until taken; a finished
// action waits for the register to free before committing to the list.
// Reset: synchronous, active low; the list comes up empty (count zero).
// Cell contents are not cleared; entries at or above the count never reach a result.
module positional_array_list_unit
    import pal_pkg::*;
#(
    parameter int DEPTH        = 32,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ACTION_W-1:0]            i_action,
    input  logic [$clog2(DEPTH)-1:0]       i_position,
    input  logic [KEY_BITS-1:0]            i_item_key,
    input  logic [PAYLOAD_BITS-1:0]        i_item_payload,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [STATUS_W-1:0]            o_status,
    output logic [$clog2(DEPTH)-1:0]       o_result_position,
    output logic [KEY_BITS-1:0]            o_out_key,
    output logic [PAYLOAD_BITS-1:0]        o_out_payload,
    output logic [$clog2(DEPTH + 1)-1:0]   o_entry_count
);

    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    pal_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_action  (i_action),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_dp_stat (dp_stat),
        .o_dp_cmd  (dp_cmd)
    );

    pal_dp #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .POS_W        (POS_W),
        .CNT_W        (CNT_W)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dp_cmd          (dp_cmd),
        .o_dp_stat         (dp_stat),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_item_key        (i_item_key),
        .i_item_payload    (i_item_payload),
        .o_status          (o_status),
        .o_result_position (o_result_position),
        .o_out_key         (o_out_key),
        .o_out_payload     (o_out_payload),
        .o_entry_count     (o_entry_count)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting a word");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= CNT_W'(DEPTH)))
        else $error("entry count above depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_FULL) |-> (o_entry_count == CNT_W'(DEPTH)))
        else $error("full status with list not full");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |->
            (o_out_key == '0 && o_out_payload == '0 && o_result_position == '0))
        else $error("nonzero result data on error status");

endmodule

/* rtl/pal_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the positional array list: accept, key scan, commit to output.
// Depends on pal_pkg.
module pal_ctrl
    import pal_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [ACTION_W-1:0] i_action,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  t_dp_stat            i_dp_stat,
    output t_dp_cmd             o_dp_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state = (i_action == ACT_FIND) ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN: begin
                o_dp_cmd.scan_step = 1'b1;
                if (i_dp_stat.scan_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!r_out_valid || !i_stall) begin
                    o_dp_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_dp_cmd.commit | (r_out_valid & i_stall);
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

/* rtl/pal_dp.sv */
`timescale 1ns / 1ps
// Datapath: register cells of the list, count, key scan and output register.
// Depends on pal_pkg.
module pal_dp
    import pal_pkg::*;
#(
    parameter int DEPTH        = 32,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 32,
    parameter int POS_W        = $clog2(DEPTH),
    parameter int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_dp_cmd,
    output t_dp_stat                o_dp_stat,
    input  logic [ACTION_W-1:0]     i_action,
    input  logic [POS_W-1:0]        i_position,
    input  logic [KEY_BITS-1:0]     i_item_key,
    input  logic [PAYLOAD_BITS-1:0] i_item_payload,
    output logic [STATUS_W-1:0]     o_status,
    output logic [POS_W-1:0]        o_result_position,
    output logic [KEY_BITS-1:0]     o_out_key,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [CNT_W-1:0]        o_entry_count
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [KEY_BITS-1:0]     r_keys [DEPTH];
    logic [PAYLOAD_BITS-1:0] r_pays [DEPTH];
    logic [KEY_BITS-1:0]     n_keys [DEPTH];
    logic [PAYLOAD_BITS-1:0] n_pays [DEPTH];
    logic [CNT_W-1:0]        r_count, n_count;

    logic [ACTION_W-1:0]     r_action;
    logic [POS_W-1:0]        r_pos;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [POS_W-1:0]        r_idx;
    logic                    r_hit;

    logic [STATUS_W-1:0]     r_status, n_status;
    logic [POS_W-1:0]        r_rpos, n_rpos;
    logic [KEY_BITS-1:0]     r_okey, n_okey;
    logic [PAYLOAD_BITS-1:0] r_opay, n_opay;
    logic [CNT_W-1:0]        r_ocnt;

    logic [CNT_W-1:0]        pos_ext, idx_ext;
    logic [POS_W-1:0]        sel_idx;
    logic [KEY_BITS-1:0]     sel_key;
    logic [PAYLOAD_BITS-1:0] sel_pay;
    logic full, pos_le, pos_lt, match, scan_done;
    logic ins_ok, app_ok, del_ok, upd_ok, rd_ok, find_hit;

    assign pos_ext  = CNT_W'(r_pos);
    assign idx_ext  = CNT_W'(r_idx);
    assign full     = (r_count == DEPTH_C);
    assign pos_le   = (pos_ext <= r_count);
    assign pos_lt   = (pos_ext < r_count);

    // single read port: scan index for find, position otherwise
    assign sel_idx  = (r_action == ACT_FIND) ? r_idx : r_pos;
    assign sel_key  = r_keys[sel_idx];
    assign sel_pay  = r_pays[sel_idx];

    assign match     = (idx_ext < r_count) && (sel_key == r_key);
    assign scan_done = match || ((idx_ext + CNT_W'(1)) >= r_count);
    assign o_dp_stat.scan_done = scan_done;

    assign ins_ok   = (r_action == ACT_INSERT) && !full && pos_le;
    assign app_ok   = (r_action == ACT_APPEND) && !full;
    assign del_ok   = (r_action == ACT_DELETE) && pos_lt;
    assign upd_ok   = (r_action == ACT_UPDATE) && pos_lt;
    assign rd_ok    = (r_action == ACT_READ) && pos_lt;
    assign find_hit = (r_action == ACT_FIND) && r_hit;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
            logic [KEY_BITS-1:0]     prev_key, next_key;
            logic [PAYLOAD_BITS-1:0] prev_pay, next_pay;
            if (g == 0) begin : g_first
                assign prev_key = r_keys[g];
                assign prev_pay = r_pays[g];
            end else begin : g_prev
                assign prev_key = r_keys[g-1];
                assign prev_pay = r_pays[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign next_key = r_keys[g];
                assign next_pay = r_pays[g];
            end else begin : g_next
                assign next_key = r_keys[g+1];
                assign next_pay = r_pays[g+1];
            end
            always_comb begin
                n_keys[g] = r_keys[g];
                n_pays[g] = r_pays[g];
                if (ins_ok) begin
                    if (IDX == pos_ext) begin
                        n_keys[g] = r_key;
                        n_pays[g] = r_pay;
                    end else if (IDX > pos_ext) begin
                        n_keys[g] = prev_key;
                        n_pays[g] = prev_pay;
                    end
                end else if (app_ok && IDX == r_count) begin
                    n_keys[g] = r_key;
                    n_pays[g] = r_pay;
                end else if (del_ok && IDX >= pos_ext) begin
                    n_keys[g] = next_key;
                    n_pays[g] = next_pay;
                end else if (upd_ok && IDX == pos_ext) begin
                    n_keys[g] = r_key;
                    n_pays[g] = r_pay;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_dp_cmd.commit) begin
                    r_keys[g] <= n_keys[g];
                    r_pays[g] <= n_pays[g];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = STAT_OK;
        n_rpos   = '0;
        n_okey   = '0;
        n_opay   = '0;
        case (r_action)
            ACT_CLEAR: begin
                n_count = '0;
            end
            ACT_INSERT: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else if (!pos_le) begin
                    n_status = STAT_BADPOS;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_APPEND: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_DELETE: begin
                if (!pos_lt) begin
                    n_status = STAT_BADPOS;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_READ: begin
                if (!rd_ok) begin
                    n_status = STAT_BADPOS;
                end else begin
                    n_okey = sel_key;
                    n_opay = sel_pay;
                end
            end
            ACT_UPDATE: begin
                if (!upd_ok) begin
                    n_status = STAT_BADPOS;
                end
            end
            ACT_FIND: begin
                if (find_hit) begin
                    n_rpos = r_idx;
                    n_okey = sel_key;
                    n_opay = sel_pay;
                end else begin
                    n_status = STAT_NOKEY;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_dp_cmd.commit) begin
                r_count <= n_count;
            end
            if (i_dp_cmd.load) begin
                r_hit <= 1'b0;
                r_idx <= '0;
            end else if (i_dp_cmd.scan_step) begin
                if (match) begin
                    r_hit <= 1'b1;
                end else if (!scan_done) begin
                    r_idx <= r_idx + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_action <= i_action;
            r_pos    <= i_position;
            r_key    <= i_item_key;
            r_pay    <= i_item_payload;
        end
        if (i_dp_cmd.commit) begin
            r_status <= n_status;
            r_rpos   <= n_rpos;
            r_okey   <= n_okey;
            r_opay   <= n_opay;
            r_ocnt   <= n_count;
        end
    end

    assign o_status          = r_status;
    assign o_result_position = r_rpos;
    assign o_out_key         = r_okey;
    assign o_out_payload     = r_opay;
    assign o_entry_count     = r_ocnt;

endmodule

/* bench/pal_list_checker.sv */
`timescale 1ns / 1ps
// Checker for the positional array list unit: watches both channels, predicts
// each result word from a private copy of the list and compares field by field.
// Depends on pal_pkg for action and status codes.
module pal_list_checker
    import pal_pkg::*;
#(
    parameter int DEPTH        = 32,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 32,
    localparam int POS_W       = $clog2(DEPTH),
    localparam int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [ACTION_W-1:0]     i_action,
    input  logic [POS_W-1:0]        i_position,
    input  logic [KEY_BITS-1:0]     i_item_key,
    input  logic [PAYLOAD_BITS-1:0] i_item_payload,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [STATUS_W-1:0]     i_status,
    input  logic [POS_W-1:0]        i_result_position,
    input  logic [KEY_BITS-1:0]     i_out_key,
    input  logic [PAYLOAD_BITS-1:0] i_out_payload,
    input  logic [CNT_W-1:0]        i_entry_count,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [POS_W-1:0]        rpos;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [CNT_W-1:0]        count;
    } t_list_result;

    logic [KEY_BITS-1:0]     list_keys     [DEPTH];
    logic [PAYLOAD_BITS-1:0] list_payloads [DEPTH];
    int                      list_len   = 0;
    t_list_result            pending_results [$];
    int                      fails      = 0;
    int                      words_seen = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: result %0d %s mismatch: got 0x%0h, expected 0x%0h",
                 $time, words_seen, what, got, want);
        fails++;
    endtask

    task automatic apply_action(input logic [ACTION_W-1:0] act,
                                input logic [POS_W-1:0] pos,
                                input logic [KEY_BITS-1:0] key,
                                input logic [PAYLOAD_BITS-1:0] payload,
                                output t_list_result res);
        int  p;
        int  q;
        bit  hit;
        res = '0;
        p   = int'(pos);
        hit = 1'b0;
        case (act)
            ACT_CLEAR: begin
                list_len = 0;
            end
            ACT_INSERT: begin
                if (list_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (p > list_len) begin
                    res.status = STAT_BADPOS;
                end else begin
                    for (q = list_len; q > p; q--) begin
                        list_keys[q]     = list_keys[q-1];
                        list_payloads[q] = list_payloads[q-1];
                    end
                    list_keys[p]     = key;
                    list_payloads[p] = payload;
                    list_len++;
                end
            end
            ACT_APPEND: begin
                if (list_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    list_keys[list_len]     = key;
                    list_payloads[list_len] = payload;
                    list_len++;
                end
            end
            ACT_DELETE: begin
                if (p >= list_len) begin
                    res.status = STAT_BADPOS;
                end else begin
                    for (q = p; q + 1 < list_len; q++) begin
                        list_keys[q]     = list_keys[q+1];
                        list_payloads[q] = list_payloads[q+1];
                    end
                    list_len--;
                end
            end
            ACT_READ: begin
                if (p >= list_len) begin
                    res.status = STAT_BADPOS;
                end else begin
                    res.key     = list_keys[p];
                    res.payload = list_payloads[p];
                end
            end
            ACT_UPDATE: begin
                if (p >= list_len) begin
                    res.status = STAT_BADPOS;
                end else begin
                    list_keys[p]     = key;
                    list_payloads[p] = payload;
                end
            end
            ACT_FIND: begin
                res.status = STAT_NOKEY;
                for (q = 0; q < list_len && !hit; q++) begin
                    if (list_keys[q] == key) begin
                        hit         = 1'b1;
                        res.status  = STAT_OK;
                        res.rpos    = POS_W'(q);
                        res.key     = list_keys[q];
                        res.payload = list_payloads[q];
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = CNT_W'(list_len);
    endtask

    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        t_list_result res;
        if (!i_rst_n) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_result_position, i_out_key, i_out_payload,
                        i_entry_count};
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", 64'(got.status), 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.rpos !== want.rpos)
                        report_mismatch("position", 64'(got.rpos), 64'(want.rpos));
                    if (got.key !== want.key)
                        report_mismatch("key", 64'(got.key), 64'(want.key));
                    if (got.payload !== want.payload)
                        report_mismatch("payload", 64'(got.payload), 64'(want.payload));
                    if (got.count !== want.count)
                        report_mismatch("count", 64'(got.count), 64'(want.count));
                end
                words_seen++;
            end
            if (i_in_valid && !i_in_stall) begin
                apply_action(i_action, i_position, i_item_key, i_item_payload, res);
                pending_results.push_back(res);
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fails;
    end

endmodule

/* bench/tb_positional_array_list_unit.sv */
`timescale 1ns / 1ps
// Testbench top for positional_array_list_unit: directed and random action
// words with random gaps and stalls on both channels. Depends on pal_pkg,
// the block and pal_list_checker, which predicts and compares the results.
module tb_positional_array_list_unit;
    import pal_pkg::*;

    localparam int DEPTH        = 32;
    localparam int KEY_BITS     = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int POS_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_NOP = 3'd7;

    localparam int RANDOM_WORDS = 650;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD    = 120;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic [ACTION_W-1:0]     i_action       = '0;
    logic [POS_W-1:0]        i_position     = '0;
    logic [KEY_BITS-1:0]     i_item_key     = '0;
    logic [PAYLOAD_BITS-1:0] i_item_payload = '0;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic [POS_W-1:0]        o_result_position;
    logic [KEY_BITS-1:0]     o_out_key;
    logic [PAYLOAD_BITS-1:0] o_out_payload;
    logic [CNT_W-1:0]        o_entry_count;

    int                      fail_count;
    int                      pending;
    int                      idle_cycles = 0;
    int                      seen_count  = 0;
    bit                      hold_req    = 1'b0;
    int                      send_burst  = 0;
    bit                      growing     = 1'b1;
    logic [KEY_BITS-1:0]     key_pool [8];

    always #5 i_clk = ~i_clk;

    positional_array_list_unit #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_item_key        (i_item_key),
        .i_item_payload    (i_item_payload),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_result_position (o_result_position),
        .o_out_key         (o_out_key),
        .o_out_payload     (o_out_payload),
        .o_entry_count     (o_entry_count)
    );

    pal_list_checker #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) list_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_item_key        (i_item_key),
        .i_item_payload    (i_item_payload),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_status          (o_status),
        .i_result_position (o_result_position),
        .i_out_key         (o_out_key),
        .i_out_payload     (o_out_payload),
        .i_entry_count     (o_entry_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // watchdog: cycles without a word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // last count seen on the output, used only to aim positions
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            seen_count <= int'(o_entry_count);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, quiet stretches, and one long hold on request
    initial begin
        int hold;
        int quiet_left;
        bit held;
        quiet_left = 0;
        held       = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                if (quiet_left > 0) begin
                    hold = 0;
                    quiet_left--;
                end else begin
                    hold = pick_gap();
                    if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(20, 60);
                end
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input logic [ACTION_W-1:0] act, input int pos,
                             input logic [KEY_BITS-1:0] key,
                             input logic [PAYLOAD_BITS-1:0] payload);
        int gap;
        if (send_burst > 0) begin
            gap = 0;
            send_burst--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            i_valid        <= 1'b0;
            i_action       <= ACTION_W'($urandom);
            i_position     <= POS_W'($urandom);
            i_item_key     <= {$urandom, $urandom};
            i_item_payload <= PAYLOAD_BITS'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_position     <= POS_W'(pos);
        i_item_key     <= key;
        i_item_payload <= payload;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_all_done();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_word();
        logic [ACTION_W-1:0]     act;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        int                      r;
        int                      pos;
        int                      top_pos;
        if (growing && seen_count >= DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
        if (!growing && seen_count <= 1 && $urandom_range(0, 1) == 0) growing = 1'b1;
        r = $urandom_range(0, 99);
        if (growing) begin
            if (r < 30)      act = ACT_INSERT;
            else if (r < 55) act = ACT_APPEND;
            else if (r < 62) act = ACT_DELETE;
            else if (r < 74) act = ACT_READ;
            else if (r < 82) act = ACT_UPDATE;
            else if (r < 95) act = ACT_FIND;
            else if (r < 96) act = ACT_CLEAR;
            else             act = ACT_NOP;
        end else begin
            if (r < 8)       act = ACT_INSERT;
            else if (r < 16) act = ACT_APPEND;
            else if (r < 50) act = ACT_DELETE;
            else if (r < 65) act = ACT_READ;
            else if (r < 73) act = ACT_UPDATE;
            else if (r < 93) act = ACT_FIND;
            else if (r < 94) act = ACT_CLEAR;
            else             act = ACT_NOP;
        end
        top_pos = (seen_count > DEPTH - 1) ? DEPTH - 1 : seen_count;
        if ($urandom_range(0, 9) < 8) pos = $urandom_range(0, top_pos);
        else                          pos = $urandom_range(0, DEPTH - 1);
        // pool keys make finds hit and give duplicate keys
        if ($urandom_range(0, 3) != 0) key = key_pool[$urandom_range(0, 7)];
        else                           key = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 5)       payload = '0;
        else if (r < 10) payload = '1;
        else             payload = PAYLOAD_BITS'($urandom);
        send_word(act, pos, key, payload);
    endtask

    initial begin
        int n;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < 8; n++) key_pool[n] = {$urandom, $urandom};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every access misses
        send_word(ACT_FIND,   0, '1, '0);
        send_word(ACT_READ,   0, '0, '0);
        send_word(ACT_DELETE, 0, '0, '0);
        send_word(ACT_UPDATE, 0, '1, '1);
        send_word(ACT_INSERT, 1, '1, '1);
        // build a short list: front, tail, at end, middle
        send_word(ACT_INSERT, 0, '1, '1);
        send_word(ACT_APPEND, 31, '0, '0);
        send_word(ACT_INSERT, 2, key_pool[2], 32'h8000_0001);
        send_word(ACT_INSERT, 1, key_pool[3], 32'h1234_5678);
        // duplicate key at the tail; find must return the first one
        send_word(ACT_UPDATE, 3, '1, 32'h0F0F_0F0F);
        send_word(ACT_FIND, 17, '1, '0);
        send_word(ACT_FIND, 0, '0, '1);
        for (n = 0; n < 4; n++) send_word(ACT_READ, n, '0, '0);
        send_word(ACT_READ, 31, '0, '0);
        send_word(ACT_NOP, 5, key_pool[4], 32'hDEAD_BEEF);
        send_word(ACT_DELETE, 4, '0, '0);
        send_word(ACT_DELETE, 3, '0, '0);
        send_word(ACT_DELETE, 0, '0, '0);
        send_word(ACT_FIND, 0, key_pool[7], '0);
        send_word(ACT_CLEAR, 9, '1, '1);
        send_word(ACT_FIND, 0, key_pool[3], '0);
        send_word(ACT_APPEND, 0, key_pool[5], 32'h0000_0001);
        wait_all_done();

        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 60) hold_req = 1'b1;
            if (n == RANDOM_WORDS / 2) wait_all_done();
            random_word();
        end

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* positional_array_list_unit.f */
rtl/pal_pkg.sv
rtl/pal_ctrl.sv
rtl/pal_dp.sv
rtl/positional_array_list.sv
bench/pal_list_checker.sv
bench/tb_positional_array_list_unit.sv
